FILE: rtl/core/bq3_pkg.sv
// Shared types, widths and constants of the three-axis biquad filter.
package bq3_pkg;

   localparam int LANES          = 3;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 18;
   localparam int FRAC_BITS      = 15;
   localparam int NUM_COEFS      = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   // Five products summed need three guard bits.
   localparam int ACC_BITS       = PROD_BITS + 3;

   typedef logic signed [SAMPLE_BITS-1:0] bq3_sample_type;
   typedef logic signed [COEF_BITS-1:0]   bq3_coef_type;
   typedef logic signed [PROD_BITS-1:0]   bq3_prod_type;
   typedef logic signed [ACC_BITS-1:0]    bq3_acc_type;

   typedef struct packed {
      bq3_coef_type b0;
      bq3_coef_type b1;
      bq3_coef_type b2;
      bq3_coef_type a1;
      bq3_coef_type a2;
   } bq3_coefs_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4
   } bq3_csr_index_type;

   // Pipeline stage load strobes shared by the lanes and the output stage.
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
   } bq3_ctrl_type;

   // Unity gain in Q2.15.
   localparam bq3_coef_type COEF_B0_RESET = bq3_coef_type'(64'sd1 <<< FRAC_BITS);

   localparam bq3_acc_type ROUND_CONST = bq3_acc_type'(64'sd1 <<< (FRAC_BITS - 1));
   localparam bq3_acc_type SAT_MAX =
      bq3_acc_type'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam bq3_acc_type SAT_MIN = bq3_acc_type'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   localparam bq3_sample_type SAMPLE_MAX = bq3_sample_type'(SAT_MAX);
   localparam bq3_sample_type SAMPLE_MIN = bq3_sample_type'(SAT_MIN);

endpackage

FILE: rtl/core/bq3_if.sv
// Valid/ready channel interfaces for sample requests and filtered responses.
interface bq3_req_if;
   logic                    valid;
   logic                    ready;
   bq3_pkg::bq3_sample_type x_sample;
   bq3_pkg::bq3_sample_type y_sample;
   bq3_pkg::bq3_sample_type z_sample;

   modport source (output valid, output x_sample, output y_sample, output z_sample,
                   input ready);
   modport sink (input valid, input x_sample, input y_sample, input z_sample,
                 output ready);
endinterface

interface bq3_rsp_if;
   logic                    valid;
   logic                    ready;
   bq3_pkg::bq3_sample_type x_filtered;
   bq3_pkg::bq3_sample_type y_filtered;
   bq3_pkg::bq3_sample_type z_filtered;
   logic                    clipped;

   modport source (output valid, output x_filtered, output y_filtered,
                   output z_filtered, output clipped, input ready);
   modport sink (input valid, input x_filtered, input y_filtered,
                 input z_filtered, input clipped, output ready);
endinterface

FILE: rtl/core/bq3_csr.sv
// Coefficient register file written through the plain configuration port.
module bq3_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [bq3_pkg::CSR_INDEX_BITS-1:0]   wr_index,
   input  logic [bq3_pkg::COEF_BITS-1:0]        wr_data,
   output bq3_pkg::bq3_coefs_type               coefs
);

   bq3_pkg::bq3_coefs_type coefs_ff;
   bq3_pkg::bq3_coefs_type coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (wr_en) begin
         unique case (bq3_pkg::bq3_csr_index_type'(wr_index))
            bq3_pkg::CSR_COEF_B0: coefs_in.b0 = bq3_pkg::bq3_coef_type'(wr_data);
            bq3_pkg::CSR_COEF_B1: coefs_in.b1 = bq3_pkg::bq3_coef_type'(wr_data);
            bq3_pkg::CSR_COEF_B2: coefs_in.b2 = bq3_pkg::bq3_coef_type'(wr_data);
            bq3_pkg::CSR_COEF_A1: coefs_in.a1 = bq3_pkg::bq3_coef_type'(wr_data);
            bq3_pkg::CSR_COEF_A2: coefs_in.a2 = bq3_pkg::bq3_coef_type'(wr_data);
            default:              coefs_in    = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= bq3_pkg::COEF_B0_RESET;
         coefs_ff.b1 <= '0;
         coefs_ff.b2 <= '0;
         coefs_ff.a1 <= '0;
         coefs_ff.a2 <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

FILE: rtl/core/bq3_lane.sv
// One axis of the filter: feedforward products, their sum, and the feedback stage.
module bq3_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  bq3_pkg::bq3_ctrl_type   ctrl,
   input  bq3_pkg::bq3_coefs_type  coefs,
   input  bq3_pkg::bq3_sample_type sample,
   output bq3_pkg::bq3_sample_type result,
   output logic                    clip
);

   // Filter history, cleared at reset.
   bq3_pkg::bq3_sample_type x1_ff, x2_ff, y1_ff, y2_ff;

   // Stage A: feedforward products.
   bq3_pkg::bq3_prod_type p0_ff, p1_ff, p2_ff;
   bq3_pkg::bq3_prod_type p0_in, p1_in, p2_in;

   // Stage B: feedforward sum with the rounding offset already added.
   bq3_pkg::bq3_acc_type ff_ff, ff_in;

   // Stage C: feedback terms, rounding and saturation.
   bq3_pkg::bq3_prod_type fb1, fb2;
   bq3_pkg::bq3_acc_type  acc, shifted;

   always_comb begin
      p0_in = coefs.b0 * sample;
      p1_in = coefs.b1 * x1_ff;
      p2_in = coefs.b2 * x2_ff;
      ff_in = bq3_pkg::bq3_acc_type'(p0_ff) + bq3_pkg::bq3_acc_type'(p1_ff)
            + bq3_pkg::bq3_acc_type'(p2_ff) + bq3_pkg::ROUND_CONST;
   end

   always_comb begin
      fb1     = coefs.a1 * y1_ff;
      fb2     = coefs.a2 * y2_ff;
      acc     = ff_ff - bq3_pkg::bq3_acc_type'(fb1) - bq3_pkg::bq3_acc_type'(fb2);
      shifted = acc >>> bq3_pkg::FRAC_BITS;
      if (shifted > bq3_pkg::SAT_MAX) begin
         result = bq3_pkg::SAMPLE_MAX;
         clip   = 1'b1;
      end else if (shifted < bq3_pkg::SAT_MIN) begin
         result = bq3_pkg::SAMPLE_MIN;
         clip   = 1'b1;
      end else begin
         result = bq3_pkg::bq3_sample_type'(shifted[bq3_pkg::SAMPLE_BITS-1:0]);
         clip   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         if (ctrl.load_a) begin
            x2_ff <= x1_ff;
            x1_ff <= sample;
         end
         if (ctrl.load_c) begin
            y2_ff <= y1_ff;
            y1_ff <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (ctrl.load_b) begin
         ff_ff <= ff_in;
      end
   end

endmodule

FILE: rtl/core/bq3_merge.sv
// Output stage: gathers the lane results, combines their clip flags and drives the response.
module bq3_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  bq3_pkg::bq3_ctrl_type   ctrl,
   input  bq3_pkg::bq3_sample_type lane_result [bq3_pkg::LANES],
   input  logic [bq3_pkg::LANES-1:0] lane_clip,
   output logic                    space,
   bq3_rsp_if.source               rsp
);

   logic                    valid_ff, valid_in;
   logic                    clipped_ff;
   bq3_pkg::bq3_sample_type filtered_ff [bq3_pkg::LANES];

   // The register can take a new result when empty or when its result leaves now.
   assign space = !valid_ff || rsp.ready;

   always_comb begin
      if (ctrl.load_c) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_c) begin
         filtered_ff <= lane_result;
         clipped_ff  <= |lane_clip;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.x_filtered = filtered_ff[0];
   assign rsp.y_filtered = filtered_ff[1];
   assign rsp.z_filtered = filtered_ff[2];
   assign rsp.clipped    = clipped_ff;

endmodule

FILE: rtl/core/biquad_iir_filter_three_axis.sv
// Three-axis biquad filter (direct form I) with shared Q2.15 coefficients and saturating output.
//
// Each request transaction carries one signed 16-bit sample per axis; each axis runs its own
// second-order section y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 with the same five coefficients,
// rounds half up at bit 15, saturates to 16 bits and feeds the saturated value back. The three
// axes are handled by three identical lanes working in parallel, and an output stage merges
// their results and ORs their clip flags into one response transaction. A transaction can be
// accepted on every clock cycle while responses are taken; it passes through the feedforward
// products, the feedforward sum, then the feedback stage that writes the output register, whose
// valid flag marks the response. The feedback stage, with its two multipliers, accumulate,
// round and saturate, is the one loop that must close with no pipeline register inside it, and
// so sets the clock rate. Requests keep flowing while a response waits, until all three stages
// hold a transaction. The filter history is cleared by reset and b0 resets to unity, so the
// block passes samples through untouched until programmed. Coefficients are to be written
// through the csr port only while the block is idle; the block itself does not enforce this.
// Indexes beyond the fifth register are ignored.
module biquad_iir_filter_three_axis (
   input  logic                                 clock,
   input  logic                                 reset,
   bq3_req_if.sink                              req_ch,
   bq3_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [bq3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bq3_pkg::COEF_BITS-1:0]        csr_data
);

   bq3_pkg::bq3_coefs_type  coefs;
   bq3_pkg::bq3_ctrl_type   ctrl;
   bq3_pkg::bq3_sample_type lane_in     [bq3_pkg::LANES];
   bq3_pkg::bq3_sample_type lane_result [bq3_pkg::LANES];
   logic [bq3_pkg::LANES-1:0] lane_clip;

   logic valid_a_ff, valid_a_in;
   logic valid_b_ff, valid_b_in;
   logic ready_a, ready_b, ready_c;

   bq3_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .coefs    (coefs)
   );

   // Each stage moves on when it is empty or when the stage after it takes its transaction.
   assign ready_b      = !valid_b_ff || ready_c;
   assign ready_a      = !valid_a_ff || ready_b;
   assign req_ch.ready = ready_a;

   assign ctrl.load_a = req_ch.valid && ready_a;
   assign ctrl.load_b = valid_a_ff && ready_b;
   assign ctrl.load_c = valid_b_ff && ready_c;

   always_comb begin
      if (ctrl.load_a) begin
         valid_a_in = 1'b1;
      end else if (ctrl.load_b) begin
         valid_a_in = 1'b0;
      end else begin
         valid_a_in = valid_a_ff;
      end
      if (ctrl.load_b) begin
         valid_b_in = 1'b1;
      end else if (ctrl.load_c) begin
         valid_b_in = 1'b0;
      end else begin
         valid_b_in = valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   // Lane order follows the axis order of the transaction.
   assign lane_in[0] = req_ch.x_sample;
   assign lane_in[1] = req_ch.y_sample;
   assign lane_in[2] = req_ch.z_sample;

   for (genvar i = 0; i < bq3_pkg::LANES; i++) begin : g_lane
      bq3_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .coefs  (coefs),
         .sample (lane_in[i]),
         .result (lane_result[i]),
         .clip   (lane_clip[i])
      );
   end

   bq3_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .lane_result (lane_result),
      .lane_clip   (lane_clip),
      .space       (ready_c),
      .rsp         (rsp_ch)
   );

   // A flagged response must carry at least one axis at a rail.
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.clipped) |->
         (rsp_ch.x_filtered == bq3_pkg::SAMPLE_MAX || rsp_ch.x_filtered == bq3_pkg::SAMPLE_MIN ||
          rsp_ch.y_filtered == bq3_pkg::SAMPLE_MAX || rsp_ch.y_filtered == bq3_pkg::SAMPLE_MIN ||
          rsp_ch.z_filtered == bq3_pkg::SAMPLE_MAX || rsp_ch.z_filtered == bq3_pkg::SAMPLE_MIN))
      else $error("clipped response without a saturated axis");

   // With every stage occupied and the response stalled, no request may be taken.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (valid_a_ff && valid_b_ff && rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request accepted into a full pipeline");

   // A transaction leaving the feedback stage must appear as a response.
   a_load_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(ctrl.load_c)) |-> rsp_ch.valid)
      else $error("feedback stage result lost");

endmodule

FILE: dv/biquad_iir_filter_three_axis_test.sv
// Self-checking testbench for the three-axis biquad filter: directed corner cases, then random traffic.
module biquad_iir_filter_three_axis_test;
   import bq3_pkg::*;

   // Roughly this share of cycles is spent idle on each side, unless a steady stretch is running.
   localparam int IDLE_PERCENT  = 27;
   // Cycles without any transaction on either channel before the run is abandoned. The slowest
   // correct run, a coefficient update plus the pipeline drain, never gets near this.
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 400;
   // Quiet margin kept once every response due has come back.
   localparam int SETTLE_CYCLES = 6;

   localparam bq3_coef_type COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam bq3_coef_type COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam bq3_coef_type COEF_HALF = bq3_coef_type'(64'sd1 <<< (FRAC_BITS - 1));
   localparam bq3_coef_type COEF_NEG_UNITY = bq3_coef_type'(-(64'sd1 <<< FRAC_BITS));

   // Coefficient styles used by the random phases.
   localparam int STYLE_WILD    = 0;
   localparam int STYLE_STABLE  = 1;
   localparam int STYLE_EXTREME = 2;

   typedef struct packed {
      bq3_sample_type x;
      bq3_sample_type y;
      bq3_sample_type z;
      logic           clipped;
   } filtered_rec_type;

   // The scoreboard keeps its own copy of the coefficients and of every axis's history, and
   // turns each accepted request transaction into the response transaction it must cause.
   class biquad_scoreboard;
      bq3_coefs_type    coefs;
      bq3_sample_type   in_d1[LANES];
      bq3_sample_type   in_d2[LANES];
      bq3_sample_type   out_d1[LANES];
      bq3_sample_type   out_d2[LANES];
      filtered_rec_type expected_filtered[$];
      int unsigned      mismatch_count;

      function new();
         coefs    = '0;
         coefs.b0 = COEF_B0_RESET;
         foreach (in_d1[i]) begin
            in_d1[i]  = '0;
            in_d2[i]  = '0;
            out_d1[i] = '0;
            out_d2[i] = '0;
         end
         mismatch_count = 0;
      endfunction

      // Indexes past the last coefficient are dropped, as the block does.
      function void write_coef(logic [CSR_INDEX_BITS-1:0] index, bq3_coef_type value);
         case (index)
            CSR_COEF_B0: coefs.b0 = value;
            CSR_COEF_B1: coefs.b1 = value;
            CSR_COEF_B2: coefs.b2 = value;
            CSR_COEF_A1: coefs.a1 = value;
            CSR_COEF_A2: coefs.a2 = value;
            default: ;
         endcase
      endfunction

      function void take_sample(bq3_sample_type xs, bq3_sample_type ys, bq3_sample_type zs);
         bq3_sample_type   fresh[LANES];
         bq3_sample_type   filtered[LANES];
         longint           acc;
         filtered_rec_type rec;
         int               lane;
         fresh[0]    = xs;
         fresh[1]    = ys;
         fresh[2]    = zs;
         rec.clipped = 1'b0;
         for (lane = 0; lane < LANES; lane++) begin
            acc = longint'(coefs.b0) * longint'(fresh[lane])
                + longint'(coefs.b1) * longint'(in_d1[lane])
                + longint'(coefs.b2) * longint'(in_d2[lane])
                - longint'(coefs.a1) * longint'(out_d1[lane])
                - longint'(coefs.a2) * longint'(out_d2[lane]);
            // Add half an LSB and shift: ties round towards plus infinity.
            acc = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (acc > longint'(SAMPLE_MAX)) begin
               filtered[lane] = SAMPLE_MAX;
               rec.clipped    = 1'b1;
            end else if (acc < longint'(SAMPLE_MIN)) begin
               filtered[lane] = SAMPLE_MIN;
               rec.clipped    = 1'b1;
            end else begin
               filtered[lane] = bq3_sample_type'(acc);
            end
            // The saturated value is what goes back into the feedback path.
            in_d2[lane]  = in_d1[lane];
            in_d1[lane]  = fresh[lane];
            out_d2[lane] = out_d1[lane];
            out_d1[lane] = filtered[lane];
         end
         rec.x = filtered[0];
         rec.y = filtered[1];
         rec.z = filtered[2];
         expected_filtered.push_back(rec);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_filtered(filtered_rec_type got);
         filtered_rec_type want;
         if (expected_filtered.size() == 0) begin
            report_mismatch($sformatf("response x=%0d y=%0d z=%0d clipped=%0b with none due",
                                      got.x, got.y, got.z, got.clipped));
            return;
         end
         want = expected_filtered.pop_front();
         if (got.x !== want.x)
            report_mismatch($sformatf("x_filtered %0d, expected %0d", got.x, want.x));
         if (got.y !== want.y)
            report_mismatch($sformatf("y_filtered %0d, expected %0d", got.y, want.y));
         if (got.z !== want.z)
            report_mismatch($sformatf("z_filtered %0d, expected %0d", got.z, want.z));
         if (got.clipped !== want.clipped)
            report_mismatch($sformatf("clipped %0b, expected %0b", got.clipped, want.clipped));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [COEF_BITS-1:0]      csr_data;
   // While this is set neither side idles, so the pipeline runs at full rate.
   bit                        steady_flow;
   int unsigned               quiet_cycles;
   biquad_scoreboard          filter_board;

   bq3_req_if req_bus ();
   bq3_rsp_if rsp_bus ();

   biquad_iir_filter_three_axis u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The response side decides at each falling edge whether to take a transaction on the next
   // rising edge, so back-pressure lands on every stage of the pipeline over the run.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Responses are sampled at the rising edge, before the block's own updates for that edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         filter_board.check_filtered({rsp_bus.x_filtered, rsp_bus.y_filtered,
                                      rsp_bus.z_filtered, rsp_bus.clipped});
   end

   // Watchdog: a long run of cycles with no transaction on either channel means the block has
   // hung, whether it stopped accepting requests or stopped producing responses.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("biquad_iir_filter_three_axis test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request transaction, with a random gap in front of it, and hands it to the
   // scoreboard once the block has taken it. Entered and left just after a falling edge.
   task automatic send_sample(bq3_sample_type xs, bq3_sample_type ys, bq3_sample_type zs);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.x_sample = xs;
      req_bus.y_sample = ys;
      req_bus.z_sample = zs;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      filter_board.take_sample(xs, ys, zs);
      @(negedge clock);
   endtask

   // Waits until every response due has come back, then lets the pipeline go quiet.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (filter_board.expected_filtered.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, bq3_coef_type value);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      filter_board.write_coef(index, value);
   endtask

   // Coefficients only change with the block idle. With partial set, some registers keep their
   // old value, so settings also mix across phases.
   task automatic program_filter(bq3_coef_type b0, bq3_coef_type b1, bq3_coef_type b2,
                                 bq3_coef_type a1, bq3_coef_type a2, bit partial);
      settle();
      if (!partial || $urandom_range(9) < 7) write_csr(CSR_COEF_B0, b0);
      if (!partial || $urandom_range(9) < 7) write_csr(CSR_COEF_B1, b1);
      if (!partial || $urandom_range(9) < 7) write_csr(CSR_COEF_B2, b2);
      if (!partial || $urandom_range(9) < 7) write_csr(CSR_COEF_A1, a1);
      if (!partial || $urandom_range(9) < 7) write_csr(CSR_COEF_A2, a2);
   endtask

   // Mostly full-range samples, with the range limits and small values mixed in.
   function automatic bq3_sample_type pick_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               3: return bq3_sample_type'(-1);
               default: return bq3_sample_type'(1);
            endcase
         end
         1: return bq3_sample_type'(int'($urandom_range(512)) - 256);
         default: return bq3_sample_type'($urandom);
      endcase
   endfunction

   // A stable filter keeps |a1| + |a2| no larger than one, so its outputs stay mostly unsaturated and the
   // feedback path is exercised with ordinary values; the other styles drive it into clipping.
   function automatic bq3_coef_type pick_coef(int style, bit feedback);
      if (style == STYLE_WILD)
         return bq3_coef_type'($urandom);
      if (style == STYLE_STABLE) begin
         if (feedback)
            return bq3_coef_type'(int'($urandom_range(32768)) - 16384);
         return bq3_coef_type'(int'($urandom_range(65536)) - 32768);
      end
      case ($urandom_range(4))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3: return COEF_B0_RESET;
         default: return COEF_NEG_UNITY;
      endcase
   endfunction

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned phase_len;
      int          style;
      int          idx;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_bus.valid    = 1'b0;
      req_bus.x_sample = '0;
      req_bus.y_sample = '0;
      req_bus.z_sample = '0;
      steady_flow      = 1'b0;
      filter_board     = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Straight after reset b0 is unity and the rest are zero, so samples pass unchanged,
      // including both ends of the range.
      send_sample(SAMPLE_MAX, SAMPLE_MIN, '0);
      send_sample(bq3_sample_type'(-1), bq3_sample_type'(1), SAMPLE_MIN);
      send_sample('0, SAMPLE_MAX, bq3_sample_type'(-1));

      // A gain of one half puts odd inputs exactly on the rounding tie: plus a half rounds up
      // to one, minus a half rounds up to zero, minus one and a half to minus one.
      program_filter(COEF_HALF, '0, '0, '0, '0, 1'b0);
      send_sample(bq3_sample_type'(1), bq3_sample_type'(-1), bq3_sample_type'(3));
      send_sample(bq3_sample_type'(-3), bq3_sample_type'(2), bq3_sample_type'(-2));

      // Every coefficient at an end of its range, so both saturation limits are hit. The
      // writes to the unused register indexes must leave the coefficients alone.
      program_filter(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN, 1'b0);
      for (idx = NUM_COEFS; idx < (1 << CSR_INDEX_BITS); idx++)
         write_csr(CSR_INDEX_BITS'(idx), pick_coef(STYLE_WILD, 1'b0));
      send_sample(SAMPLE_MAX, SAMPLE_MIN, bq3_sample_type'(1));
      send_sample(SAMPLE_MIN, SAMPLE_MAX, bq3_sample_type'(-1));
      send_sample('0, '0, '0);
      send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);

      // An integrator (a1 of minus one) climbs into saturation through the feedback path alone,
      // and must then hold at the limit rather than wrap.
      program_filter(COEF_B0_RESET, '0, '0, COEF_NEG_UNITY, '0, 1'b0);
      repeat (3) send_sample(bq3_sample_type'(20000), bq3_sample_type'(-20000),
                             bq3_sample_type'(100));

      // The most negative gain times the most negative sample gives the largest positive sum.
      program_filter(COEF_MIN, '0, '0, '0, '0, 1'b0);
      send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
      send_sample(bq3_sample_type'(1), bq3_sample_type'(-1), '0);

      // Random phases, each with its own coefficient set. The third phase is long and runs
      // without any idling, so the pipeline is seen full with every stage busy.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         style = $urandom_range(STYLE_EXTREME);
         program_filter(pick_coef(style, 1'b0), pick_coef(style, 1'b0), pick_coef(style, 1'b0),
                        pick_coef(style, 1'b1), pick_coef(style, 1'b1), phase != 0);
         steady_flow = (phase == 2);
         phase_len   = steady_flow ? 100 : $urandom_range(10, 50);
         repeat (phase_len) begin
            send_sample(pick_sample(), pick_sample(), pick_sample());
            random_sent++;
         end
         steady_flow = 1'b0;
         phase++;
      end

      settle();
      if (filter_board.mismatch_count == 0)
         $display("biquad_iir_filter_three_axis test passed");
      else
         $display("biquad_iir_filter_three_axis test failed");
      $finish;
   end

endmodule
